>>> hw/rtl/bba_pkg.sv
// Types, constants and the compare sequence table of the bounding box accumulator.
package bba_pkg;

  localparam int COORD_BITS    = 32;
  localparam int COUNT_BITS    = 16;
  localparam int SUM_BITS      = COORD_BITS + COUNT_BITS;
  localparam int ALU_BITS      = SUM_BITS + 1;
  localparam int STEP_BITS     = 4;
  localparam int ITER_BITS     = $clog2(SUM_BITS);
  localparam int CMD_BITS      = 3;
  localparam int IN_DATA_BITS  = 6 * COORD_BITS;
  localparam int OUT_RAW_BITS  = 6 * COORD_BITS + 1 + COUNT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_RAW_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic signed [COORD_BITS-1:0] COORD_MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR     = 3'd0,
    CMD_ADD       = 3'd1,
    CMD_EXTENT    = 3'd2,
    CMD_HAS_POINT = 3'd3,
    CMD_HAS_BOX   = 3'd4,
    CMD_OVERLAP   = 3'd5,
    CMD_AVERAGE   = 3'd6,
    CMD_NOP       = 3'd7
  } bba_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SUM_X,
    ST_SUM_Y,
    ST_ABS,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } bba_state_t;

  // Compare operand sources
  typedef enum logic [3:0] {
    SRC_X,
    SRC_Y,
    SRC_XL,
    SRC_XH,
    SRC_YL,
    SRC_YH,
    SRC_OXL,
    SRC_OXH,
    SRC_OYL,
    SRC_OYH
  } bba_src_t;

  // One compare step: lt = a < b (signed)
  typedef struct packed {
    bba_src_t a_sel;
    bba_src_t b_sel;
    logic     last;
  } bba_uop_t;

  function automatic bba_uop_t uop_of(bba_cmd_t cmd, logic [STEP_BITS-1:0] step);
    bba_uop_t u;
    u = '{a_sel: SRC_X, b_sel: SRC_XL, last: 1'b0};
    case (cmd)
      CMD_HAS_BOX: begin
        u.last = (step[1:0] == 2'd3);
        case (step[1:0])
          2'd0:    begin u.a_sel = SRC_OXL; u.b_sel = SRC_XL;  end
          2'd1:    begin u.a_sel = SRC_XH;  u.b_sel = SRC_OXH; end
          2'd2:    begin u.a_sel = SRC_OYL; u.b_sel = SRC_YL;  end
          default: begin u.a_sel = SRC_YH;  u.b_sel = SRC_OYH; end
        endcase
      end
      CMD_OVERLAP: begin
        u.last = (step == '1);
        case (step)
          4'd0:    begin u.a_sel = SRC_XL;  u.b_sel = SRC_OXL; end
          4'd1:    begin u.a_sel = SRC_OXL; u.b_sel = SRC_XH;  end
          4'd2:    begin u.a_sel = SRC_XL;  u.b_sel = SRC_OXH; end
          4'd3:    begin u.a_sel = SRC_OXH; u.b_sel = SRC_XH;  end
          4'd4:    begin u.a_sel = SRC_YL;  u.b_sel = SRC_OYL; end
          4'd5:    begin u.a_sel = SRC_OYL; u.b_sel = SRC_YH;  end
          4'd6:    begin u.a_sel = SRC_YL;  u.b_sel = SRC_OYH; end
          4'd7:    begin u.a_sel = SRC_OYH; u.b_sel = SRC_YH;  end
          4'd8:    begin u.a_sel = SRC_OXL; u.b_sel = SRC_XL;  end
          4'd9:    begin u.a_sel = SRC_XL;  u.b_sel = SRC_OXH; end
          4'd10:   begin u.a_sel = SRC_OXL; u.b_sel = SRC_XH;  end
          4'd11:   begin u.a_sel = SRC_XH;  u.b_sel = SRC_OXH; end
          4'd12:   begin u.a_sel = SRC_OYL; u.b_sel = SRC_YL;  end
          4'd13:   begin u.a_sel = SRC_YL;  u.b_sel = SRC_OYH; end
          4'd14:   begin u.a_sel = SRC_OYL; u.b_sel = SRC_YH;  end
          default: begin u.a_sel = SRC_YH;  u.b_sel = SRC_OYH; end
        endcase
      end
      default: begin
        // add, extent and contains point share the point-vs-box compares
        u.last = (step[1:0] == 2'd3);
        case (step[1:0])
          2'd0:    begin u.a_sel = SRC_X;  u.b_sel = SRC_XL; end
          2'd1:    begin u.a_sel = SRC_XH; u.b_sel = SRC_X;  end
          2'd2:    begin u.a_sel = SRC_Y;  u.b_sel = SRC_YL; end
          default: begin u.a_sel = SRC_YH; u.b_sel = SRC_Y;  end
        endcase
      end
    endcase
    return u;
  endfunction

  // Strict overlap of the second box's corners against the first, from eight compares
  function automatic logic side_of(logic [7:0] b);
    return ((b[0] & b[1]) | (b[2] & b[3])) & ((b[4] & b[5]) | (b[6] & b[7]));
  endfunction

endpackage

>>> hw/rtl/bounding_box_accumulator_unit.sv
// Bounding box accumulator: box, coordinate sums and point count under a shared-adder sequencer.
// One command is taken per transfer and one result comes back per command; the block takes
// no new command until the result is taken. Every step runs through a single 49-bit
// add/subtract unit, one operation per cycle, which sets the latency. Clear and no-op go
// straight to the result; add, extent and contains point/box run their compares, add
// point then updates both sums (skipped when the count is saturated), overlap runs the
// compares of both boxes, and average runs per axis an absolute value, restoring division
// and a sign fix (none when the count is zero). The output state offers the result until taken.
// Coordinates are signed Q16.16; the count saturates at all ones and the sums then hold.
module bounding_box_accumulator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // x_coord, y_coord, other_x_low, other_x_high, other_y_low, other_y_high
  input  logic [bba_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
  // cmd
  input  logic [bba_pkg::CMD_BITS-1:0]     s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // box_x_low, box_x_high, box_y_low, box_y_high, avg_x, avg_y, answer_flag, points_seen
  output logic [bba_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  // avg_valid
  output logic                             m_axis_tuser
);
  import bba_pkg::*;

  bba_state_t state, state_next;

  bba_cmd_t                      cmd_in;
  logic signed [COORD_BITS-1:0]  x_in, y_in, oxl_in, oxh_in, oyl_in, oyh_in;

  logic signed [COORD_BITS-1:0]  x_low, x_high, y_low, y_high;
  logic signed [SUM_BITS-1:0]    sum_x, sum_y;
  logic [COUNT_BITS-1:0]         point_count;

  logic signed [COORD_BITS-1:0]  avg_x, avg_y;
  logic                          avg_valid, answer_flag;

  logic [STEP_BITS-1:0]          step;
  logic [(1<<STEP_BITS)-1:0]     cmp_bits, cmp_now;
  logic [ITER_BITS-1:0]          iter;
  logic                          axis_y, neg;
  logic [SUM_BITS-1:0]           div_d;
  logic [COUNT_BITS-1:0]         rem;

  logic [ALU_BITS-1:0]           alu_a, alu_b, alu_res;
  logic                          alu_sub;
  logic                          lt, ge;
  bba_uop_t                      uop;
  logic                          accept;
  logic signed [SUM_BITS-1:0]    cur_sum;

  function automatic logic [ALU_BITS-1:0] sext_coord(logic signed [COORD_BITS-1:0] v);
    return {{(ALU_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick(bba_src_t s,
      logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
      logic signed [COORD_BITS-1:0] xl, logic signed [COORD_BITS-1:0] xh,
      logic signed [COORD_BITS-1:0] yl, logic signed [COORD_BITS-1:0] yh,
      logic signed [COORD_BITS-1:0] oxl, logic signed [COORD_BITS-1:0] oxh,
      logic signed [COORD_BITS-1:0] oyl, logic signed [COORD_BITS-1:0] oyh);
    case (s)
      SRC_X:   return x;
      SRC_Y:   return y;
      SRC_XL:  return xl;
      SRC_XH:  return xh;
      SRC_YL:  return yl;
      SRC_YH:  return yh;
      SRC_OXL: return oxl;
      SRC_OXH: return oxh;
      SRC_OYL: return oyl;
      SRC_OYH: return oyh;
      default: return x;
    endcase
  endfunction

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign uop     = uop_of(cmd_in, step);
  assign cur_sum = axis_y ? sum_y : sum_x;

  // Shared add/subtract unit
  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(ALU_BITS-1){1'b0}}, alu_sub};
  assign lt      = alu_res[ALU_BITS-1];
  assign ge      = ~alu_res[ALU_BITS-1];
  assign cmp_now = cmp_bits | ({{((1<<STEP_BITS)-1){1'b0}}, lt} << step);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_CMP: begin
        alu_a   = sext_coord(pick(uop.a_sel, x_in, y_in, x_low, x_high, y_low, y_high,
                                  oxl_in, oxh_in, oyl_in, oyh_in));
        alu_b   = sext_coord(pick(uop.b_sel, x_in, y_in, x_low, x_high, y_low, y_high,
                                  oxl_in, oxh_in, oyl_in, oyh_in));
        alu_sub = 1'b1;
      end
      ST_SUM_X: begin
        alu_a = {sum_x[SUM_BITS-1], sum_x};
        alu_b = sext_coord(x_in);
      end
      ST_SUM_Y: begin
        alu_a = {sum_y[SUM_BITS-1], sum_y};
        alu_b = sext_coord(y_in);
      end
      ST_ABS: begin
        alu_b   = {cur_sum[SUM_BITS-1], cur_sum};
        alu_sub = cur_sum[SUM_BITS-1];
      end
      ST_DIV: begin
        // trial subtract of the divisor from the shifted partial remainder
        alu_a   = {{(ALU_BITS-COUNT_BITS-1){1'b0}}, rem, div_d[SUM_BITS-1]};
        alu_b   = {{(ALU_BITS-COUNT_BITS){1'b0}}, point_count};
        alu_sub = 1'b1;
      end
      ST_FIX: begin
        alu_b   = {1'b0, div_d};
        alu_sub = neg;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (bba_cmd_t'(s_axis_tuser))
            CMD_CLEAR, CMD_NOP: state_next = ST_OUT;
            CMD_AVERAGE:        state_next = (point_count == '0) ? ST_OUT : ST_ABS;
            default:            state_next = ST_CMP;
          endcase
        end
      end
      ST_CMP: begin
        if (uop.last) begin
          if (cmd_in == CMD_ADD && point_count != COUNT_MAX) state_next = ST_SUM_X;
          else                                                state_next = ST_OUT;
        end
      end
      ST_SUM_X: state_next = ST_SUM_Y;
      ST_SUM_Y: state_next = ST_OUT;
      ST_ABS:   state_next = ST_DIV;
      ST_DIV:   if (iter == ITER_BITS'(SUM_BITS - 1)) state_next = ST_FIX;
      ST_FIX:   state_next = axis_y ? ST_OUT : ST_ABS;
      ST_OUT:   if (m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low       <= COORD_MAXV;
      y_low       <= COORD_MAXV;
      x_high      <= COORD_MINV;
      y_high      <= COORD_MINV;
      sum_x       <= '0;
      sum_y       <= '0;
      point_count <= '0;
      avg_valid   <= 1'b0;
      answer_flag <= 1'b0;
      step        <= '0;
      iter        <= '0;
      axis_y      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_in      <= bba_cmd_t'(s_axis_tuser);
            x_in        <= s_axis_tdata[0*COORD_BITS +: COORD_BITS];
            y_in        <= s_axis_tdata[1*COORD_BITS +: COORD_BITS];
            oxl_in      <= s_axis_tdata[2*COORD_BITS +: COORD_BITS];
            oxh_in      <= s_axis_tdata[3*COORD_BITS +: COORD_BITS];
            oyl_in      <= s_axis_tdata[4*COORD_BITS +: COORD_BITS];
            oyh_in      <= s_axis_tdata[5*COORD_BITS +: COORD_BITS];
            avg_x       <= '0;
            avg_y       <= '0;
            avg_valid   <= 1'b0;
            answer_flag <= 1'b0;
            cmp_bits    <= '0;
            step        <= '0;
            axis_y      <= 1'b0;
            if (bba_cmd_t'(s_axis_tuser) == CMD_CLEAR) begin
              x_low       <= COORD_MAXV;
              y_low       <= COORD_MAXV;
              x_high      <= COORD_MINV;
              y_high      <= COORD_MINV;
              sum_x       <= '0;
              sum_y       <= '0;
              point_count <= '0;
            end
          end
        end
        ST_CMP: begin
          cmp_bits <= cmp_now;
          step     <= step + 1'b1;
          if ((cmd_in == CMD_ADD || cmd_in == CMD_EXTENT) && lt) begin
            case (step[1:0])
              2'd0:    x_low  <= x_in;
              2'd1:    x_high <= x_in;
              2'd2:    y_low  <= y_in;
              default: y_high <= y_in;
            endcase
          end
          if (uop.last) begin
            case (cmd_in)
              CMD_HAS_POINT, CMD_HAS_BOX: answer_flag <= ~|cmp_now[3:0];
              CMD_OVERLAP: answer_flag <= side_of(cmp_now[7:0]) | side_of(cmp_now[15:8]);
              default:     answer_flag <= 1'b0;
            endcase
          end
        end
        ST_SUM_X: sum_x <= alu_res[SUM_BITS-1:0];
        ST_SUM_Y: begin
          sum_y       <= alu_res[SUM_BITS-1:0];
          point_count <= point_count + 1'b1;
        end
        ST_ABS: begin
          div_d <= alu_res[SUM_BITS-1:0];
          neg   <= cur_sum[SUM_BITS-1];
          rem   <= '0;
          iter  <= '0;
        end
        ST_DIV: begin
          // remainder stays below the divisor, so its top bit drops safely
          rem   <= ge ? alu_res[COUNT_BITS-1:0] : {rem[COUNT_BITS-2:0], div_d[SUM_BITS-1]};
          div_d <= {div_d[SUM_BITS-2:0], ge};
          iter  <= iter + 1'b1;
        end
        ST_FIX: begin
          if (axis_y) begin
            avg_y     <= alu_res[COORD_BITS-1:0];
            avg_valid <= 1'b1;
          end else begin
            avg_x <= alu_res[COORD_BITS-1:0];
          end
          axis_y <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tuser  = avg_valid;
  assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, point_count, answer_flag, avg_y, avg_x,
                          y_high, y_low, x_high, x_low};

  a_one_side: assert property (@(posedge clk) disable iff (rst)
      !(s_axis_tready && m_axis_tvalid))
    else $error("input and output offered together");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
      (point_count != $past(point_count)) |->
        (point_count == $past(point_count) + 1'b1 || point_count == '0))
    else $error("point count moved by other than one or a clear");

  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
      (point_count == COUNT_MAX && $past(point_count) == COUNT_MAX) |->
        (sum_x == $past(sum_x) && sum_y == $past(sum_y)))
    else $error("sums changed with count saturated");

  a_avg_valid: assert property (@(posedge clk) disable iff (rst)
      (m_axis_tvalid && m_axis_tuser) |-> (point_count != '0 && cmd_in == CMD_AVERAGE))
    else $error("average marked valid without points");

endmodule
